// ===== hw/rtl/fqsr_pkg.sv =====
// Shared types and codes for the FIFO queue with search and remove.
package fqsr_pkg;

	localparam int DEPTH_DEFAULT = 16;
	localparam int VALUE_W = 32;
	localparam int COUNT_W = 5;

	typedef enum logic [1:0] {
		OP_PUSH   = 2'd0,
		OP_POP    = 2'd1,
		OP_SEARCH = 2'd2,
		OP_REMOVE = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] head_value;
		logic [COUNT_W-1:0]        entry_count;
		logic                      is_empty;
		logic                      found;
		logic [COUNT_W-1:0]        removed_count;
		status_t                   status;
	} res_t;

endpackage

// ===== hw/rtl/fqsr_mem.sv =====
// Entry store: one write port and one registered read port.
module fqsr_mem #(
	parameter int DEPTH = fqsr_pkg::DEPTH_DEFAULT,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic                               clk,
	input  logic                               we,
	input  logic [AW-1:0]                      waddr,
	input  logic [fqsr_pkg::VALUE_W-1:0]       wdata,
	input  logic                               re,
	input  logic [AW-1:0]                      raddr,
	output logic [fqsr_pkg::VALUE_W-1:0]       rdata
);

	logic [fqsr_pkg::VALUE_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hw/rtl/fqsr_seq.sv =====
// Command sequencer: ring pointers, scan loop and the shared equality compare.
module fqsr_seq #(
	parameter int DEPTH = fqsr_pkg::DEPTH_DEFAULT,
	localparam int AW = $clog2(DEPTH),
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [1:0]                         in_op,
	input  logic signed [fqsr_pkg::VALUE_W-1:0] in_value,
	output logic                               res_valid,
	input  logic                               res_ready,
	output fqsr_pkg::res_t                     res,
	output logic                               mem_we,
	output logic [AW-1:0]                      mem_waddr,
	output logic [fqsr_pkg::VALUE_W-1:0]       mem_wdata,
	output logic                               mem_re,
	output logic [AW-1:0]                      mem_raddr,
	input  logic [fqsr_pkg::VALUE_W-1:0]       mem_rdata
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_HEAD,
		S_HDATA,
		S_DONE
	} state_t;

	state_t                       state_q;
	logic [AW-1:0]                hd_q;
	logic [CW-1:0]                cnt_q;
	logic [CW-1:0]                idx_q;
	logic [CW-1:0]                keep_q;
	logic [CW-1:0]                rmv_q;
	logic                         rd_v_q;
	logic                         found_q;
	fqsr_pkg::op_t                op_q;
	fqsr_pkg::status_t            status_q;
	logic [fqsr_pkg::VALUE_W-1:0] val_q;
	logic [fqsr_pkg::VALUE_W-1:0] head_q;

	logic                         accept;
	logic                         issue;
	logic                         hit;
	logic                         full;
	fqsr_pkg::op_t                op_in;

	// Ring address: base plus offset, folded back below DEPTH.
	function automatic logic [AW-1:0] wrap(input logic [AW-1:0] a, input logic [AW-1:0] b);
		logic [AW:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= (AW+1)'(DEPTH)) begin
			s = s - (AW+1)'(DEPTH);
		end
		return s[AW-1:0];
	endfunction

	function automatic logic [fqsr_pkg::COUNT_W-1:0] cnt5(input logic [CW-1:0] c);
		logic [CW+fqsr_pkg::COUNT_W-1:0] t;
		t = {{fqsr_pkg::COUNT_W{1'b0}}, c};
		return t[fqsr_pkg::COUNT_W-1:0];
	endfunction

	assign op_in    = fqsr_pkg::op_t'(in_op);
	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign full     = (cnt_q == CW'(DEPTH));
	assign issue    = (state_q == S_SCAN) && (idx_q != cnt_q);
	assign hit      = (mem_rdata == val_q);

	assign mem_re    = issue || (state_q == S_HEAD);
	assign mem_raddr = (state_q == S_HEAD) ? hd_q : wrap(hd_q, idx_q[AW-1:0]);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = wrap(hd_q, cnt_q[AW-1:0]);
		mem_wdata = in_value;
		if (accept && (op_in == fqsr_pkg::OP_PUSH) && !full) begin
			mem_we = 1'b1;
		end else if ((state_q == S_SCAN) && rd_v_q && (op_q == fqsr_pkg::OP_REMOVE) && !hit) begin
			// A kept entry slides down to the next free slot behind the read point.
			mem_we    = 1'b1;
			mem_waddr = wrap(hd_q, keep_q[AW-1:0]);
			mem_wdata = mem_rdata;
		end
	end

	assign res_valid         = (state_q == S_DONE);
	assign res.head_value    = head_q;
	assign res.entry_count   = cnt5(cnt_q);
	assign res.is_empty      = (cnt_q == '0);
	assign res.found         = found_q;
	assign res.removed_count = cnt5(rmv_q);
	assign res.status        = status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			hd_q     <= '0;
			cnt_q    <= '0;
			idx_q    <= '0;
			keep_q   <= '0;
			rmv_q    <= '0;
			rd_v_q   <= 1'b0;
			found_q  <= 1'b0;
			op_q     <= fqsr_pkg::OP_PUSH;
			status_q <= fqsr_pkg::ST_OK;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q     <= op_in;
						val_q    <= in_value;
						found_q  <= 1'b0;
						rmv_q    <= '0;
						idx_q    <= '0;
						keep_q   <= '0;
						rd_v_q   <= 1'b0;
						status_q <= fqsr_pkg::ST_OK;
						case (op_in)
							fqsr_pkg::OP_PUSH: begin
								if (full) begin
									status_q <= fqsr_pkg::ST_FULL;
								end else begin
									cnt_q <= cnt_q + CW'(1);
								end
								state_q <= S_HEAD;
							end
							fqsr_pkg::OP_POP: begin
								if (cnt_q == '0) begin
									status_q <= fqsr_pkg::ST_EMPTY;
								end else begin
									hd_q  <= wrap(hd_q, AW'(1));
									cnt_q <= cnt_q - CW'(1);
								end
								state_q <= S_HEAD;
							end
							default: begin
								state_q <= S_SCAN;
							end
						endcase
					end
				end
				S_SCAN: begin
					rd_v_q <= issue;
					if (issue) begin
						idx_q <= idx_q + CW'(1);
					end
					if (rd_v_q) begin
						if (hit) begin
							if (op_q == fqsr_pkg::OP_SEARCH) begin
								found_q <= 1'b1;
							end
							if (op_q == fqsr_pkg::OP_REMOVE) begin
								rmv_q <= rmv_q + CW'(1);
							end
						end else if (op_q == fqsr_pkg::OP_REMOVE) begin
							keep_q <= keep_q + CW'(1);
						end
					end
					if (!issue && !rd_v_q) begin
						if (op_q == fqsr_pkg::OP_REMOVE) begin
							cnt_q <= keep_q;
						end
						state_q <= S_HEAD;
					end
				end
				S_HEAD: begin
					state_q <= S_HDATA;
				end
				S_HDATA: begin
					head_q  <= (cnt_q == '0) ? '0 : mem_rdata;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== hw/rtl/fifo_queue_with_search_remove_core.sv =====
// Top level of the FIFO queue with search and remove, with its output register.
//
// A bounded queue of signed 32-bit values kept in a ring buffer memory.
// Commands arrive on the s_axis channel: s_axis_tuser carries the operation
// (push, pop, search, remove all matching) and s_axis_tdata the value.
// Each command yields exactly one item on the m_axis channel describing the
// queue afterwards: head value, entry count, empty flag, search hit, number
// of entries removed and a status code.
// The block takes one command at a time. Push and pop go from acceptance
// through the head read (S_HEAD, S_HDATA) to the result being offered, and
// the next command can be taken once that result has been handed on; search
// and remove first run a scan (S_SCAN), since one shared equality compare
// visits every stored entry in turn, one memory read per cycle, and remove
// writes each kept entry back through the single write port in the same pass.
// A result waits in an output register, so the next command may be accepted
// while the receiver stalls; if that command finishes before the register is
// free, the sequencer holds its result until the register drains.
// Reset empties the queue at once (the memory itself is not cleared; only
// entries below the count are ever used).
module fifo_queue_with_search_remove_core #(
	parameter int DEPTH = fqsr_pkg::DEPTH_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // [31:0] value
	input  logic [1:0]  s_axis_tuser,  // [1:0] operation
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [31:0] head_value, [36:32] entry_count, [37] is_empty, [38] found,
	// [43:39] removed_count, [45:44] status, [47:46] zero
	output logic [47:0] m_axis_tdata
);

	localparam int AW = $clog2(DEPTH);

	logic                         res_valid;
	logic                         res_ready;
	fqsr_pkg::res_t               res;
	fqsr_pkg::res_t               out_q;
	logic                         out_valid_q;

	logic                         mem_we;
	logic [AW-1:0]                mem_waddr;
	logic [fqsr_pkg::VALUE_W-1:0] mem_wdata;
	logic                         mem_re;
	logic [AW-1:0]                mem_raddr;
	logic [fqsr_pkg::VALUE_W-1:0] mem_rdata;

	fqsr_seq #(
		.DEPTH(DEPTH)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_op     (s_axis_tuser),
		.in_value  (s_axis_tdata),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	fqsr_mem #(
		.DEPTH(DEPTH)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// The output register can take a new result when it is empty or being drained.
	assign res_ready = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (res_valid && res_ready) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {2'b00, out_q.status, out_q.removed_count, out_q.found,
		out_q.is_empty, out_q.entry_count, out_q.head_value};

	// Once a command is taken, the block is busy for at least the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("command accepted while the previous one was still in progress");

	// A result handed to the output register is offered on the next cycle.
	a_result_offered: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready |=> m_axis_tvalid)
		else $error("finished result was not presented");

	// A dropped push or an empty pop never reports a search hit or removals.
	a_error_fields_clear: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (out_q.status != fqsr_pkg::ST_OK) |->
		!out_q.found && (out_q.removed_count == '0))
		else $error("error result carries search or remove fields");

endmodule
